// ===== hw/rtl/cibs_pkg.sv =====
// Package for the camera interval and bulb sequencer: codes, structs and
// millisecond lookup tables. No dependencies; imported by every RTL file.
`default_nettype none

package cibs_pkg;

    localparam int CD_W     = 20;
    localparam int DONE_W   = 16;
    localparam int TARGET_W = 8;
    localparam int SEL_W    = 3;
    localparam int MODE_W   = 2;
    localparam int REQ_W    = 2;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 3;

    // Request types
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READY = 2'd3;

    // Commands to the camera
    localparam logic [CMD_W-1:0] CMD_NONE       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PHOTO      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BULB_OPEN  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BULB_CLOSE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd4;

    // Tool modes
    localparam logic [MODE_W-1:0] MODE_INTERVAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIMELAPSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BULB      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TOOL_MODE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL_SEL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_SEL    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPOSURE_SEL = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAUSE_SEL    = 3'd4;

    localparam logic [CD_W-1:0]   START_DELAY_MS = 20'd500;
    localparam logic [CD_W-1:0]   CD_MAX         = 20'd570000;
    localparam logic [DONE_W-1:0] DONE_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [MODE_W-1:0] tool_mode;
        logic [SEL_W-1:0]  interval_sel;
        logic [SEL_W-1:0]  count_sel;
        logic [SEL_W-1:0]  exposure_sel;
        logic [SEL_W-1:0]  pause_sel;
    } t_cfg;

    typedef struct packed {
        logic                running;
        logic                bulb;
        logic                nr;
        logic [CD_W-1:0]     countdown;
        logic [DONE_W-1:0]   done;
        logic [TARGET_W-1:0] target;
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [STATUS_W-1:0] status;
        logic                is_running;
        logic                bulb_open;
        logic                nr_wait;
        logic [DONE_W-1:0]   shots_done;
        logic [TARGET_W-1:0] shot_target;
        logic [CD_W-1:0]     remaining_ms;
    } t_result;

    // Interval in ms; indexes past the table read its last entry.
    function automatic logic [CD_W-1:0] interval_ms(input logic [SEL_W-1:0] sel);
        case (sel)
            3'd0:    interval_ms = 20'd1000;
            3'd1:    interval_ms = 20'd2000;
            3'd2:    interval_ms = 20'd5000;
            3'd3:    interval_ms = 20'd10000;
            3'd4:    interval_ms = 20'd30000;
            default: interval_ms = 20'd60000;
        endcase
    endfunction

    function automatic logic [TARGET_W-1:0] shot_count(input logic [SEL_W-1:0] sel);
        case (sel)
            3'd0:    shot_count = 8'd10;
            3'd1:    shot_count = 8'd25;
            3'd2:    shot_count = 8'd50;
            3'd3:    shot_count = 8'd100;
            default: shot_count = 8'd250;
        endcase
    endfunction

    // Bulb exposure in ms.
    function automatic logic [CD_W-1:0] exposure_ms(input logic [SEL_W-1:0] sel);
        case (sel)
            3'd0:    exposure_ms = 20'd5000;
            3'd1:    exposure_ms = 20'd10000;
            3'd2:    exposure_ms = 20'd15000;
            3'd3:    exposure_ms = 20'd20000;
            3'd4:    exposure_ms = 20'd30000;
            3'd5:    exposure_ms = 20'd60000;
            3'd6:    exposure_ms = 20'd120000;
            default: exposure_ms = 20'd180000;
        endcase
    endfunction

    // Noise reduction timeout in ms: three exposures plus thirty seconds.
    function automatic logic [CD_W-1:0] nr_timeout_ms(input logic [SEL_W-1:0] sel);
        case (sel)
            3'd0:    nr_timeout_ms = 20'd45000;
            3'd1:    nr_timeout_ms = 20'd60000;
            3'd2:    nr_timeout_ms = 20'd75000;
            3'd3:    nr_timeout_ms = 20'd90000;
            3'd4:    nr_timeout_ms = 20'd120000;
            3'd5:    nr_timeout_ms = 20'd210000;
            3'd6:    nr_timeout_ms = 20'd390000;
            default: nr_timeout_ms = 20'd570000;
        endcase
    endfunction

    function automatic logic [CD_W-1:0] pause_ms(input logic [SEL_W-1:0] sel);
        case (sel)
            3'd0:    pause_ms = 20'd1000;
            3'd1:    pause_ms = 20'd2000;
            3'd2:    pause_ms = 20'd3000;
            3'd3:    pause_ms = 20'd5000;
            3'd4:    pause_ms = 20'd10000;
            default: pause_ms = 20'd30000;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cibs_step.sv =====
// Next-state and result logic for one transaction of the sequencer.
// Purely combinational; depends on cibs_pkg.
`default_nettype none

module cibs_step (
    input  wire cibs_pkg::t_state            i_state,
    input  wire cibs_pkg::t_cfg              i_cfg,
    input  wire logic [cibs_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic                        i_link_up,
    input  wire logic                        i_camera_accepts,
    output cibs_pkg::t_state                 o_state,
    output cibs_pkg::t_result                o_result
);
    import cibs_pkg::*;

    t_state             s;
    logic [CMD_W-1:0]   cmd;
    logic [STATUS_W-1:0] status;
    logic               special;
    logic               bulb_mode;

    assign bulb_mode = (i_cfg.tool_mode == MODE_BULB);

    always_comb begin
        s       = i_state;
        cmd     = CMD_NONE;
        status  = ST_IDLE;
        special = 1'b0;

        case (i_req_type)
            REQ_TICK: begin
                if (s.countdown != '0) begin
                    s.countdown = s.countdown - 1'b1;
                end
                if (s.running && i_link_up && (s.countdown == '0)) begin
                    if (bulb_mode) begin
                        if (s.nr) begin
                            s.nr = 1'b0;
                            if (s.done >= {{(DONE_W-TARGET_W){1'b0}}, s.target}) begin
                                s.running = 1'b0;
                                status    = ST_COMPLETED;
                                special   = 1'b1;
                            end else begin
                                s.countdown = pause_ms(i_cfg.pause_sel);
                            end
                        end else if (!s.bulb) begin
                            if (i_camera_accepts) begin
                                s.bulb      = 1'b1;
                                s.countdown = exposure_ms(i_cfg.exposure_sel);
                                cmd         = CMD_BULB_OPEN;
                            end
                        end else begin
                            s.nr   = 1'b1;
                            s.bulb = 1'b0;
                            if (s.done != DONE_MAX) begin
                                s.done = s.done + 1'b1;
                            end
                            cmd         = CMD_BULB_CLOSE;
                            s.countdown = nr_timeout_ms(i_cfg.exposure_sel);
                        end
                    end else begin
                        if (i_camera_accepts) begin
                            if (s.done != DONE_MAX) begin
                                s.done = s.done + 1'b1;
                            end
                            cmd = CMD_PHOTO;
                        end
                        if ((s.target != '0) &&
                            (s.done >= {{(DONE_W-TARGET_W){1'b0}}, s.target})) begin
                            s.running = 1'b0;
                            status    = ST_COMPLETED;
                            special   = 1'b1;
                        end else begin
                            s.countdown = interval_ms(i_cfg.interval_sel);
                        end
                    end
                end
            end
            REQ_START: begin
                if (!i_link_up) begin
                    status  = ST_REFUSED;
                    special = 1'b1;
                end else begin
                    s.done      = '0;
                    s.target    = (i_cfg.tool_mode == MODE_INTERVAL) ? '0
                                  : shot_count(i_cfg.count_sel);
                    s.countdown = START_DELAY_MS;
                    s.bulb      = 1'b0;
                    s.nr        = 1'b0;
                    s.running   = 1'b1;
                end
            end
            REQ_STOP: begin
                if (s.bulb) begin
                    cmd = CMD_BULB_CLOSE;
                end
                s.bulb    = 1'b0;
                s.nr      = 1'b0;
                s.running = 1'b0;
                status    = ST_STOPPED;
                special   = 1'b1;
            end
            default: begin
                // Shutter-ready notice ends a noise reduction wait early.
                if (s.running && bulb_mode && s.nr) begin
                    s.nr = 1'b0;
                    if (s.done >= {{(DONE_W-TARGET_W){1'b0}}, s.target}) begin
                        s.running = 1'b0;
                        status    = ST_COMPLETED;
                        special   = 1'b1;
                    end else begin
                        s.countdown = pause_ms(i_cfg.pause_sel);
                    end
                end
            end
        endcase

        if (!special) begin
            status = s.running ? ST_RUNNING : ST_IDLE;
        end
    end

    assign o_state = s;

    always_comb begin
        o_result.command      = cmd;
        o_result.status       = status;
        o_result.is_running   = s.running;
        o_result.bulb_open    = s.bulb;
        o_result.nr_wait      = s.nr;
        o_result.shots_done   = s.done;
        o_result.shot_target  = s.target;
        o_result.remaining_ms = s.countdown;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/camera_interval_bulb_sequencer.sv =====
// Top level of the camera interval and bulb sequencer: configuration
// registers, sequence state, result register and skid slot.
// Depends on cibs_pkg and cibs_step.
//
// Usage. Each input transaction (i_valid high, o_stall low at a rising edge)
// carries one request: a one millisecond tick, a start, a stop or a
// shutter-ready notice from the camera. Every input transaction yields
// exactly one result transaction on the output channel (o_valid, i_stall),
// holding the camera command, a status code and a snapshot of the sequence
// state after the request.
// The result of an accepted transaction is registered: it is loaded into the
// output register, or into the skid slot while the receiver stalls. Throughput
// is one transaction per cycle while o_stall is low; the state update in
// cibs_step is combinational and feeds back into the state registers.
// When the receiver stalls, the waiting result holds in the output register
// and one further result is parked in a skid slot; o_stall rises only while
// that slot is full, and it is driven from a register.
// Configuration registers are written through i_cfg_we/i_cfg_addr/i_cfg_data
// and are read live by every transaction; writes to unknown indexes are
// ignored. The synchronous active-low reset returns the registers to their
// defaults, stops any sequence and empties both output slots.
`default_nettype none

module camera_interval_bulb_sequencer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [cibs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [cibs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Request channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [cibs_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic                                i_link_up,
    input  wire logic                                i_camera_accepts,
    // Result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [cibs_pkg::CMD_W-1:0]               o_command,
    output logic [cibs_pkg::STATUS_W-1:0]            o_status,
    output logic                                     o_is_running,
    output logic                                     o_bulb_open,
    output logic                                     o_nr_wait,
    output logic [cibs_pkg::DONE_W-1:0]              o_shots_done,
    output logic [cibs_pkg::TARGET_W-1:0]            o_shot_target,
    output logic [cibs_pkg::CD_W-1:0]                o_remaining_ms
);
    import cibs_pkg::*;

    // Configuration registers
    t_cfg    r_cfg;

    // Sequence state and its next value from the step logic
    t_state  r_st;
    t_state  n_st;
    t_result n_res;

    // Output register and skid slot
    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    logic    in_acc;
    logic    out_take;
    logic    out_free;

    // A transaction is only ever refused while the skid slot is occupied.
    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tool_mode    <= MODE_INTERVAL;
            r_cfg.interval_sel <= 3'd3;
            r_cfg.count_sel    <= 3'd2;
            r_cfg.exposure_sel <= 3'd4;
            r_cfg.pause_sel    <= 3'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TOOL_MODE:    r_cfg.tool_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_INTERVAL_SEL: r_cfg.interval_sel <= i_cfg_data[SEL_W-1:0];
                CFG_COUNT_SEL:    r_cfg.count_sel    <= i_cfg_data[SEL_W-1:0];
                CFG_EXPOSURE_SEL: r_cfg.exposure_sel <= i_cfg_data[SEL_W-1:0];
                CFG_PAUSE_SEL:    r_cfg.pause_sel    <= i_cfg_data[SEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cibs_step u_step (
        .i_state          (r_st),
        .i_cfg            (r_cfg),
        .i_req_type       (i_req_type),
        .i_link_up        (i_link_up),
        .i_camera_accepts (i_camera_accepts),
        .o_state          (n_st),
        .o_result         (n_res)
    );

    // The state advances on every accepted transaction, independent of how
    // the results drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (in_acc) begin
            r_st <= n_st;
        end
    end

    // Result ordering: the skid slot always holds the younger result, so it
    // refills the output register before any new result does.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc;
                end
            end else if (in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_res;
            end
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command      = r_out.command;
    assign o_status       = r_out.status;
    assign o_is_running   = r_out.is_running;
    assign o_bulb_open    = r_out.bulb_open;
    assign o_nr_wait      = r_out.nr_wait;
    assign o_shots_done   = r_out.shots_done;
    assign o_shot_target  = r_out.shot_target;
    assign o_remaining_ms = r_out.remaining_ms;

    // The skid slot is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a result while the output register is empty");

    // A bulb exposure and a noise reduction wait never overlap.
    a_bulb_nr_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_st.bulb && r_st.nr))
        else $error("bulb open and noise reduction wait set together");

    // Every value loaded into the countdown lies within the longest timeout.
    a_countdown_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.countdown <= CD_MAX)
        else $error("countdown beyond the longest timeout");

    // An accepted stop always leaves the sequence idle with the bulb closed.
    a_stop_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req_type == REQ_STOP)) |=> (!r_st.running && !r_st.bulb))
        else $error("sequence still active after a stop");

endmodule

`default_nettype wire
